// ===== src/xfr_pkg.sv =====
`timescale 1ns / 1ps

package xfr_pkg;

	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 6;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;
	localparam int DEF_MAX_PAYLOAD = 32;

	// register indexes on the configuration port
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_MARKER = 2'd2;

	// register reset values
	localparam logic [BYTE_W-1:0] RST_START  = 8'd2;
	localparam logic [BYTE_W-1:0] RST_END    = 8'd3;
	localparam logic [BYTE_W-1:0] RST_MARKER = 8'd35;

	// frame field position
	localparam logic [1:0] FLD_COMMAND = 2'd0;
	localparam logic [1:0] FLD_PAYLOAD = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SEND
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic step;
		logic advance;
		logic clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_end;
		logic last;
	} sts_t;

endpackage

// ===== src/xfr_ctrl.sv =====
`timescale 1ns / 1ps

module xfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  xfr_pkg::sts_t sts,
	output xfr_pkg::cmd_t cmd
);
	import xfr_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.step    = 1'b0;
		cmd.advance = 1'b0;
		cmd.clear   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.is_end) begin
						state_nxt = ST_SEND;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			ST_READ: begin
				state_nxt = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last) begin
						cmd.clear = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_nxt   = ST_READ;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/xfr_dp.sv =====
`timescale 1ns / 1ps

module xfr_dp #(
	parameter int MAX_PAYLOAD = xfr_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [xfr_pkg::DATA_W-1:0]  pwdata,
	output logic [xfr_pkg::DATA_W-1:0]  prdata,
	input  logic [xfr_pkg::BYTE_W-1:0]  rx_byte,
	input  xfr_pkg::cmd_t               cmd,
	output xfr_pkg::sts_t               sts,
	output logic [xfr_pkg::BYTE_W-1:0]  command_code,
	output logic                        frame_ok,
	output logic                        overflow,
	output logic                        has_byte,
	output logic [xfr_pkg::BYTE_W-1:0]  payload_byte,
	output logic [xfr_pkg::LEN_W-1:0]   payload_length,
	output logic                        last
);
	import xfr_pkg::*;

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [BYTE_W-1:0] start_q;
	logic [BYTE_W-1:0] end_q;
	logic [BYTE_W-1:0] marker_q;

	logic              in_frame_q;
	logic [1:0]        field_q;
	logic [BYTE_W-1:0] xor_q;
	logic              marker_seen_q;
	logic              check_taken_q;
	logic [BYTE_W-1:0] check_q;
	logic [BYTE_W-1:0] command_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [BYTE_W-1:0] rdata_q;

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

	logic [1:0] reg_idx;
	logic       cfg_wr;
	logic       is_marker;
	logic       room;
	logic       store_en;

	assign reg_idx   = paddr[3:2];
	assign cfg_wr    = psel && penable && pwrite;
	assign is_marker = (rx_byte == marker_q);
	assign room      = (cnt_q < CNT_W'(MAX_PAYLOAD));
	assign store_en  = cmd.step && in_frame_q && !marker_seen_q && !is_marker
	                   && (field_q == FLD_PAYLOAD) && room;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= RST_START;
			end_q    <= RST_END;
			marker_q <= RST_MARKER;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_START:  start_q  <= pwdata[BYTE_W-1:0];
				REG_END:    end_q    <= pwdata[BYTE_W-1:0];
				REG_MARKER: marker_q <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_START:  prdata = DATA_W'(start_q);
			REG_END:    prdata = DATA_W'(end_q);
			REG_MARKER: prdata = DATA_W'(marker_q);
			default:    prdata = '0;
		endcase
	end

	// frame parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			field_q       <= FLD_COMMAND;
			xor_q         <= '0;
			marker_seen_q <= 1'b0;
			check_taken_q <= 1'b0;
			check_q       <= '0;
			command_q     <= '0;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
		end else if (cmd.clear) begin
			in_frame_q    <= 1'b0;
			field_q       <= FLD_COMMAND;
			xor_q         <= '0;
			marker_seen_q <= 1'b0;
			check_taken_q <= 1'b0;
			check_q       <= '0;
			command_q     <= '0;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
		end else if (cmd.step) begin
			if (!in_frame_q) begin
				// outside a frame only the start symbol matters
				if (rx_byte == start_q) begin
					in_frame_q <= 1'b1;
				end
			end else if (marker_seen_q) begin
				// first byte after the marker is the check, rest ignored
				if (!check_taken_q) begin
					check_q       <= rx_byte;
					check_taken_q <= 1'b1;
				end
			end else begin
				if (field_q == FLD_COMMAND) begin
					command_q <= rx_byte;
				end
				if (is_marker) begin
					marker_seen_q <= 1'b1;
					field_q       <= FLD_PAYLOAD;
				end else begin
					xor_q <= xor_q ^ rx_byte;
					if (field_q != FLD_PAYLOAD) begin
						field_q <= 2'(field_q + 2'd1);
					end else if (room) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	// readout index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.clear) begin
			rd_idx_q <= '0;
		end else if (cmd.advance) begin
			rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
		end
	end

	// payload memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[cnt_q[AW-1:0]] <= rx_byte;
		end
		rdata_q <= mem[rd_idx_q[AW-1:0]];
	end

	// check result
	always_comb begin
		frame_ok = 1'b0;
		if (in_frame_q && (field_q != FLD_COMMAND)) begin
			if (marker_seen_q) begin
				frame_ok = check_taken_q && (check_q == xor_q);
			end else begin
				frame_ok = (xor_q == '0);
			end
		end
	end

	// result fields
	assign command_code   = command_q;
	assign overflow       = ovf_q;
	assign has_byte       = (rd_idx_q < cnt_q);
	assign payload_byte   = has_byte ? rdata_q : '0;
	assign payload_length = LEN_W'(cnt_q);
	assign last           = (({1'b0, rd_idx_q} + 1'b1) >= {1'b0, cnt_q});

	assign sts.is_end = (rx_byte == end_q);
	assign sts.last   = last;

endmodule

// ===== src/xor_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// a byte that closes no frame is taken and in_ready stays high
// throughput: one byte per cycle while no frame ends
// on the end symbol the first result is valid in the next cycle; each further
// result passes the read state once the previous one is taken (one payload
// memory read port); input is held off during readout; reset clears the frame
// state and restores the symbol registers, the payload memory is not cleared
module xor_checked_frame_receiver #(
	parameter int MAX_PAYLOAD = xfr_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [xfr_pkg::DATA_W-1:0]  pwdata,
	output logic [xfr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [xfr_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [xfr_pkg::BYTE_W-1:0]  command_code,
	output logic                        frame_ok,
	output logic                        overflow,
	output logic                        has_byte,
	output logic [xfr_pkg::BYTE_W-1:0]  payload_byte,
	output logic [xfr_pkg::LEN_W-1:0]   payload_length,
	output logic                        last
);
	import xfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	// sequencer
	xfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// parser, payload buffer and registers
	xfr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.command_code   (command_code),
		.frame_ok       (frame_ok),
		.overflow       (overflow),
		.has_byte       (has_byte),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.last           (last)
	);

`ifndef SYNTH
	// no byte is taken while a frame is being read out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during readout");

	// the final item of a frame returns the block to taking bytes
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> (in_ready && !out_valid))
		else $error("block did not return to idle after last item");

	// an item without a payload byte can only be the final one
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> last)
		else $error("empty item not marked last");

	// a frame end starts readout on the next cycle
	a_end_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && sts.is_end) |=> out_valid)
		else $error("end symbol did not start readout");
`endif

endmodule
